[design/satt_pkg.sv]
// Shared types and constants for the set-associative transposition table.
package satt_pkg;

  // Table geometry (both must be powers of two)
  localparam int CLUSTERS     = 1024;
  localparam int WAYS         = 4;
  localparam int CLUSTER_BITS = $clog2(CLUSTERS);
  localparam int WAY_BITS     = $clog2(WAYS);
  localparam int ENTRY_BITS   = CLUSTER_BITS + WAY_BITS;
  localparam int ENTRIES      = CLUSTERS * WAYS;

  // Field widths
  localparam int KEY_W   = 64;
  localparam int TAG_W   = 32;
  localparam int DATA_W  = 16;
  localparam int GEN_W   = 8;
  localparam int OWAY_W  = 2;

  // Request commands
  typedef enum logic [1:0] {
    CMD_LOOKUP     = 2'd0,
    CMD_SAVE       = 2'd1,
    CMD_REFRESH    = 2'd2,
    CMD_NEW_SEARCH = 2'd3
  } tt_cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } tt_state_t;

  // One stored entry, 88 bits
  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic signed [DATA_W-1:0] value;
    logic [DATA_W-1:0]        move;
    logic [DATA_W-1:0]        depth;
    logic [GEN_W-1:0]         gen;
  } tt_entry_t;

  // One result
  typedef struct packed {
    logic                     hit;
    logic [OWAY_W-1:0]        way;
    logic signed [DATA_W-1:0] value;
    logic [DATA_W-1:0]        move;
    logic [DATA_W-1:0]        depth;
    logic [GEN_W-1:0]         gen;
  } tt_result_t;

endpackage

[design/set_assoc_transposition_table.sv]
// Top level: set-associative transposition table with one-way-at-a-time scan.
// After reset the block clears all 4096 entries (one entry per cycle) with
// in_ready low. Then one request is handled at a time: a lookup, save or
// refresh is accepted in IDLE, scans the ways (READ, then EVAL, for each) and
// hands its result on in DONE; a new search goes from IDLE to DONE. The entry
// memory (one write and one registered read port) is read one way at a time
// into one shared tag/generation/depth compare unit. A finished result sits
// in the output register while the next request is accepted; the block only
// waits for out_ready when a second result is ready before the first is taken.
module set_assoc_transposition_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_command,
  input  logic [satt_pkg::KEY_W-1:0]         in_key,
  input  logic signed [satt_pkg::DATA_W-1:0] in_value,
  input  logic [satt_pkg::DATA_W-1:0]        in_move,
  input  logic [satt_pkg::DATA_W-1:0]        in_depth,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic [satt_pkg::OWAY_W-1:0]        out_way,
  output logic signed [satt_pkg::DATA_W-1:0] out_stored_value,
  output logic [satt_pkg::DATA_W-1:0]        out_stored_move,
  output logic [satt_pkg::DATA_W-1:0]        out_stored_depth,
  output logic [satt_pkg::GEN_W-1:0]         out_entry_generation
);
  import satt_pkg::*;

  localparam logic [WAY_BITS-1:0] LAST_WAY = WAY_BITS'(WAYS - 1);

  // Control state
  tt_state_t                state_r, state_nxt;
  logic [GEN_W-1:0]         gen_r, gen_nxt;
  logic [ENTRY_BITS-1:0]    clr_r, clr_nxt;
  logic [WAY_BITS-1:0]      way_r, way_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // Request and scan payload
  tt_cmd_t                  cmd_r, cmd_nxt;
  logic [KEY_W-1:0]         key_r, key_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0]        mov_r, mov_nxt;
  logic [DATA_W-1:0]        dep_r, dep_nxt;
  logic [WAY_BITS-1:0]      vic_way_r, vic_way_nxt;
  logic [GEN_W-1:0]         vic_gen_r, vic_gen_nxt;
  logic [DATA_W-1:0]        vic_depth_r, vic_depth_nxt;
  tt_result_t               res_r, res_nxt;
  tt_result_t               out_r, out_nxt;

  // Entry memory
  tt_entry_t                mem [ENTRIES];
  tt_entry_t                rd_q_r;
  logic                     mem_we;
  logic [ENTRY_BITS-1:0]    mem_wa;
  tt_entry_t                mem_wd;
  logic [ENTRY_BITS-1:0]    mem_ra;

  // Shared compare unit
  logic [CLUSTER_BITS-1:0]  cluster;
  logic [TAG_W-1:0]         key_tag;
  logic                     tag_hit, way_empty, cand_cur, vic_cur, shallower, replace;
  logic                     last_way;

  assign cluster   = key_r[CLUSTER_BITS-1:0];
  assign key_tag   = key_r[KEY_W-1:KEY_W-TAG_W];
  assign mem_ra    = {cluster, way_r};
  assign tag_hit   = (rd_q_r.tag == key_tag);
  assign way_empty = (rd_q_r.tag == '0);
  assign cand_cur  = (rd_q_r.gen == gen_r);
  assign vic_cur   = (vic_gen_r == gen_r);
  assign shallower = (rd_q_r.depth < vic_depth_r);
  assign last_way  = (way_r == LAST_WAY);
  // Way 0 always seeds the victim; later ways win on older generation, then depth
  assign replace   = (way_r == '0) || (vic_cur && !cand_cur) ||
                     ((vic_cur == cand_cur) && shallower);

  assign in_ready             = (state_r == ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_hit              = out_r.hit;
  assign out_way              = out_r.way;
  assign out_stored_value     = out_r.value;
  assign out_stored_move      = out_r.move;
  assign out_stored_depth     = out_r.depth;
  assign out_entry_generation = out_r.gen;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r <= mem[mem_ra];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      gen_r       <= '0;
      clr_r       <= '0;
      way_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      clr_r       <= clr_nxt;
      way_r       <= way_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    mov_r       <= mov_nxt;
    dep_r       <= dep_nxt;
    vic_way_r   <= vic_way_nxt;
    vic_gen_r   <= vic_gen_nxt;
    vic_depth_r <= vic_depth_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    clr_nxt       = clr_r;
    way_nxt       = way_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    mov_nxt       = mov_r;
    dep_nxt       = dep_r;
    vic_way_nxt   = vic_way_r;
    vic_gen_nxt   = vic_gen_r;
    vic_depth_nxt = vic_depth_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wa        = {cluster, way_r};
    mem_wd        = rd_q_r;

    // Output register drains independently of the sequencer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Zero every entry, one per cycle
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = tt_cmd_t'(in_command);
          key_nxt = in_key;
          val_nxt = in_value;
          mov_nxt = in_move;
          dep_nxt = in_depth;
          way_nxt = '0;
          res_nxt = '0;
          if (tt_cmd_t'(in_command) == CMD_NEW_SEARCH) begin
            gen_nxt   = gen_r + 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end

      // Address of the current way is presented; data arrives next cycle
      ST_READ: begin
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        if (replace) begin
          vic_way_nxt   = way_r;
          vic_gen_nxt   = rd_q_r.gen;
          vic_depth_nxt = rd_q_r.depth;
        end
        way_nxt   = way_r + 1'b1;
        state_nxt = last_way ? ST_DONE : ST_READ;
        case (cmd_r)
          CMD_LOOKUP: begin
            if (tag_hit) begin
              res_nxt.hit   = 1'b1;
              res_nxt.way   = OWAY_W'(way_r);
              res_nxt.value = rd_q_r.value;
              res_nxt.move  = rd_q_r.move;
              res_nxt.depth = rd_q_r.depth;
              res_nxt.gen   = rd_q_r.gen;
              state_nxt     = ST_DONE;
            end
          end
          CMD_REFRESH: begin
            if (tag_hit) begin
              mem_we      = 1'b1;
              mem_wd.gen  = gen_r;
              res_nxt.hit = 1'b1;
              res_nxt.way = OWAY_W'(way_r);
              state_nxt   = ST_DONE;
            end
          end
          CMD_SAVE: begin
            mem_wd.tag   = key_tag;
            mem_wd.value = val_r;
            mem_wd.move  = mov_r;
            mem_wd.depth = dep_r;
            mem_wd.gen   = gen_r;
            if (way_empty || tag_hit) begin
              // Free or matching way takes the entry
              mem_we      = 1'b1;
              res_nxt.hit = tag_hit;
              res_nxt.way = OWAY_W'(way_r);
              state_nxt   = ST_DONE;
            end else if (last_way) begin
              // Cluster full: overwrite the victim
              mem_we      = 1'b1;
              mem_wa      = {cluster, vic_way_nxt};
              res_nxt.hit = 1'b0;
              res_nxt.way = OWAY_W'(vic_way_nxt);
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/satt_checker.sv]
// Port-level checker for the transposition table, bound to the top level.
module satt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [1:0]                         in_command,
  input logic [satt_pkg::KEY_W-1:0]         in_key,
  input logic signed [satt_pkg::DATA_W-1:0] in_value,
  input logic [satt_pkg::DATA_W-1:0]        in_move,
  input logic [satt_pkg::DATA_W-1:0]        in_depth,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_hit,
  input logic [satt_pkg::OWAY_W-1:0]        out_way,
  input logic signed [satt_pkg::DATA_W-1:0] out_stored_value,
  input logic [satt_pkg::DATA_W-1:0]        out_stored_move,
  input logic [satt_pkg::DATA_W-1:0]        out_stored_depth,
  input logic [satt_pkg::GEN_W-1:0]         out_entry_generation
);

  // Reset leaves no result pending and holds off requests for the clear pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("result or ready visible right after reset");

  // One request at a time: an accepted request blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one is in flight");

  // A waiting request holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_command) && $stable(in_key) &&
                              $stable(in_value) && $stable(in_move) && $stable(in_depth))
    else $error("waiting request changed");

  // Entry data only accompanies a hit
  a_data_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_stored_depth != '0 || out_stored_move != '0 ||
                  out_stored_value != '0 || out_entry_generation != '0) |-> out_hit)
    else $error("entry data returned without a hit");

  // A stalled result holds its hit, way and depth
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_way) &&
                                $stable(out_stored_depth))
    else $error("stalled result changed");

endmodule

bind set_assoc_transposition_table satt_checker u_satt_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the set-associative transposition table.
`timescale 1ns / 100ps

module testbench;
  import satt_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int ITEMS_PER_PHASE = 270;
  localparam int GEN_BURST      = 80;
  localparam int TAG_POOL       = 8;
  localparam int CLUSTER_POOL   = 6;
  localparam logic [31:0] LAST_CLUSTER = 32'(CLUSTERS - 1);

  // Shadow table plus queue of results still owed by the block
  class tt_scoreboard;
    tt_entry_t      shadow_slots [ENTRIES];
    logic [GEN_W-1:0] cur_gen;
    tt_result_t     pending_results [$];
    int             mismatches;

    function new();
      foreach (shadow_slots[i]) shadow_slots[i] = '0;
      cur_gen    = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // first way whose tag matches, -1 when none does
    function int find_way(int base, logic [TAG_W-1:0] tag);
      int w;
      int hit_way;
      hit_way = -1;
      for (w = WAYS - 1; w >= 0; w--) begin
        if (shadow_slots[base + w].tag == tag) hit_way = w;
      end
      return hit_way;
    endfunction

    // Work out the result of one accepted request and update the shadow
    function void note_request(tt_cmd_t cmd, logic [KEY_W-1:0] key,
                               logic signed [DATA_W-1:0] value,
                               logic [DATA_W-1:0] move, logic [DATA_W-1:0] depth);
      tt_result_t       res;
      tt_entry_t        cand;
      tt_entry_t        vict;
      logic [TAG_W-1:0] tag;
      int base;
      int w;
      int victim;
      int chosen;
      int weight;
      res  = '0;
      tag  = key[KEY_W-1:KEY_W-TAG_W];
      base = int'(key[31:0] % 32'(CLUSTERS)) * WAYS;
      case (cmd)
        CMD_LOOKUP: begin
          w = find_way(base, tag);
          if (w >= 0) begin
            res.hit   = 1'b1;
            res.way   = OWAY_W'(w);
            res.value = shadow_slots[base + w].value;
            res.move  = shadow_slots[base + w].move;
            res.depth = shadow_slots[base + w].depth;
            res.gen   = shadow_slots[base + w].gen;
          end
        end
        CMD_SAVE: begin
          // first empty or matching way, else generation/depth victim
          chosen = -1;
          victim = 0;
          for (w = 0; w < WAYS && chosen < 0; w++) begin
            cand = shadow_slots[base + w];
            vict = shadow_slots[base + victim];
            if (cand.tag == '0 || cand.tag == tag) begin
              chosen = w;
            end else begin
              weight = 0;
              if (vict.gen == cur_gen) weight += 2;
              if (cand.gen == cur_gen) weight -= 2;
              if (cand.depth < vict.depth) weight += 1;
              if (weight > 0) victim = w;
            end
          end
          if (chosen < 0) chosen = victim;
          res.hit = (shadow_slots[base + chosen].tag == tag);
          res.way = OWAY_W'(chosen);
          shadow_slots[base + chosen].tag   = tag;
          shadow_slots[base + chosen].value = value;
          shadow_slots[base + chosen].move  = move;
          shadow_slots[base + chosen].depth = depth;
          shadow_slots[base + chosen].gen   = cur_gen;
        end
        CMD_REFRESH: begin
          w = find_way(base, tag);
          if (w >= 0) begin
            shadow_slots[base + w].gen = cur_gen;
            res.hit = 1'b1;
            res.way = OWAY_W'(w);
          end
        end
        default: cur_gen = cur_gen + 1'b1;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_field(string nm, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        mismatches++;
        $display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h",
                 $time, nm, exp_v, act_v);
      end
    endfunction

    // Compare one result from the block against the oldest expectation
    function void check_result(tt_result_t seen);
      tt_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual hit %0b way %0d",
                 $time, seen.hit, seen.way);
        return;
      end
      exp_r = pending_results.pop_front();
      check_field("hit", exp_r.hit, seen.hit);
      check_field("way", exp_r.way, seen.way);
      check_field("stored_value", exp_r.value, seen.value);
      check_field("stored_move", exp_r.move, seen.move);
      check_field("stored_depth", exp_r.depth, seen.depth);
      check_field("entry_generation", exp_r.gen, seen.gen);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                in_command;
  logic [KEY_W-1:0]          in_key;
  logic signed [DATA_W-1:0]  in_value;
  logic [DATA_W-1:0]         in_move;
  logic [DATA_W-1:0]         in_depth;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_hit;
  logic [OWAY_W-1:0]         out_way;
  logic signed [DATA_W-1:0]  out_stored_value;
  logic [DATA_W-1:0]         out_stored_move;
  logic [DATA_W-1:0]         out_stored_depth;
  logic [GEN_W-1:0]          out_entry_generation;

  tt_scoreboard     tt_model;
  tt_result_t       seen_result;
  int               src_idle_pct;
  int               sink_stall_pct;
  int               quiet_cycles;
  logic [TAG_W-1:0] tag_pool [TAG_POOL];
  logic [CLUSTER_BITS-1:0] cluster_pool [CLUSTER_POOL];

  set_assoc_transposition_table dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_key              (in_key),
    .in_value            (in_value),
    .in_move             (in_move),
    .in_depth            (in_depth),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_way             (out_way),
    .out_stored_value    (out_stored_value),
    .out_stored_move     (out_stored_move),
    .out_stored_depth    (out_stored_depth),
    .out_entry_generation(out_entry_generation)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check on handshake, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.hit   = out_hit;
      seen_result.way   = out_way;
      seen_result.value = out_stored_value;
      seen_result.move  = out_stored_move;
      seen_result.depth = out_stored_depth;
      seen_result.gen   = out_entry_generation;
      tt_model.check_result(seen_result);
    end
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one request and hold it until accepted
  task automatic send_request(input tt_cmd_t cmd, input logic [KEY_W-1:0] key,
                              input logic [DATA_W-1:0] value,
                              input logic [DATA_W-1:0] move,
                              input logic [DATA_W-1:0] depth);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    in_value   <= value;
    in_move    <= move;
    in_depth   <= depth;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tt_model.note_request(cmd, key, value, move, depth);
  endtask

  // Stop sending until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tt_model.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] mk_key(logic [TAG_W-1:0] tag, logic [31:0] low);
    return {tag, low};
  endfunction

  // Mostly keys from small tag/cluster pools so ways collide and hit
  function automatic logic [KEY_W-1:0] pick_key();
    logic [31:0] low;
    if ($urandom_range(99) < 15) return {$urandom, $urandom};
    low = $urandom;
    low[CLUSTER_BITS-1:0] = cluster_pool[$urandom_range(CLUSTER_POOL - 1)];
    return {tag_pool[$urandom_range(TAG_POOL - 1)], low};
  endfunction

  function automatic logic [DATA_W-1:0] pick_depth();
    if ($urandom_range(1) == 0) return DATA_W'($urandom_range(7));
    return DATA_W'($urandom);
  endfunction

  task automatic refill_pools();
    int i;
    for (i = 0; i < TAG_POOL; i++) tag_pool[i] = $urandom;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = 32'h0000_0001;
    tag_pool[3] = 32'h8000_0000;
    for (i = 0; i < CLUSTER_POOL; i++) cluster_pool[i] = CLUSTER_BITS'($urandom);
    cluster_pool[0] = '0;
    cluster_pool[1] = '1;
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)
      send_request(CMD_SAVE, pick_key(), DATA_W'($urandom), DATA_W'($urandom), pick_depth());
    else if (pick < 65)
      send_request(CMD_LOOKUP, pick_key(), DATA_W'($urandom), DATA_W'($urandom),
                   DATA_W'($urandom));
    else if (pick < 80)
      send_request(CMD_REFRESH, pick_key(), DATA_W'($urandom), DATA_W'($urandom),
                   DATA_W'($urandom));
    else
      send_request(CMD_NEW_SEARCH, {$urandom, $urandom}, DATA_W'($urandom),
                   DATA_W'($urandom), DATA_W'($urandom));
  endtask

  initial begin
    int phase;
    int n;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_LOOKUP;
    in_key         = '0;
    in_value       = '0;
    in_move        = '0;
    in_depth       = '0;
    out_ready      = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    quiet_cycles   = 0;
    tt_model       = new();
    refill_pools();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty ways, misses, fill, replacement, generation change
    send_request(CMD_LOOKUP, '0, '0, '0, '0);                     // zero tag hits empty way
    send_request(CMD_LOOKUP, '1, '0, '0, '0);                     // miss in last cluster
    send_request(CMD_REFRESH, '1, '0, '0, '0);                    // refresh miss
    send_request(CMD_SAVE, '1, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_request(CMD_LOOKUP, '1, '0, '0, '0);
    send_request(CMD_SAVE, mk_key('0, LAST_CLUSTER), 16'h7FFF, '0, '0); // zero-tag save
    send_request(CMD_LOOKUP, mk_key('0, LAST_CLUSTER), '0, '0, '0);
    send_request(CMD_SAVE, mk_key(32'h1, LAST_CLUSTER), 16'd1, 16'd2, 16'd5);
    send_request(CMD_SAVE, mk_key(32'h8000_0000, LAST_CLUSTER), 16'd3, 16'd4, 16'd3);
    send_request(CMD_SAVE, mk_key(32'h7FFF_FFFF, LAST_CLUSTER), 16'd5, 16'd6, 16'd9);
    // cluster full, all current: shallowest goes
    send_request(CMD_SAVE, mk_key(32'h0001_0000, LAST_CLUSTER), 16'd7, 16'd8, 16'd4);
    send_request(CMD_NEW_SEARCH, '0, '0, '0, '0);
    send_request(CMD_REFRESH, mk_key(32'h7FFF_FFFF, LAST_CLUSTER), '0, '0, '0);
    // older generation preferred as victim
    send_request(CMD_SAVE, mk_key(32'hDEAD_BEEF, LAST_CLUSTER), 16'hFFFF, 16'h1234, 16'd100);
    send_request(CMD_LOOKUP, mk_key(32'h7FFF_FFFF, LAST_CLUSTER), '0, '0, '0);
    send_request(CMD_SAVE, '1, 16'h0000, 16'h0000, 16'h0000);      // matching tag rewrite
    send_request(CMD_LOOKUP, mk_key(32'hDEAD_BEEF, LAST_CLUSTER), '0, '0, '0);
    send_request(CMD_NEW_SEARCH, '1, '1, '1, '1);
    send_request(CMD_LOOKUP, mk_key(32'hDEAD_BEEF, 32'hFFFF_FFFF), '0, '0, '0);
    send_request(CMD_LOOKUP, '1, '0, '0, '0);
    drain_results();

    // Random phases with different idle/stall mixes
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
        default: begin src_idle_pct = 30; sink_stall_pct = 30; end
      endcase
      refill_pools();
      // run the generation counter around so it wraps during the run
      if (phase == 2) begin
        for (n = 0; n < GEN_BURST; n++)
          send_request(CMD_NEW_SEARCH, {$urandom, $urandom}, DATA_W'($urandom),
                       DATA_W'($urandom), DATA_W'($urandom));
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_request();
      drain_results();
    end

    // Let any stray result show up before closing
    sink_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tt_model.mismatches == 0 && tt_model.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
